// ===== src/steer_impedance_controller_core_macros.svh =====
// Assertion macros for the steering impedance controller.
// Used by files under src that assert; expects clk and rst_n in scope.
`ifndef STEER_IMPEDANCE_CONTROLLER_CORE_MACROS_SVH
`define STEER_IMPEDANCE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication
`define SIC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sic_pkg.sv =====
// Shared types, constants and helper functions of the steering impedance controller.
// No dependencies; used by sic_mul_unit and steer_impedance_controller_core.
`default_nettype none

package sic_pkg;

    localparam int DATA_W    = 32;
    localparam int LIM_W     = 31;
    localparam int WIDE_W    = 66;
    localparam int WHEEL_W   = 2;
    localparam int CFG_IDX_W = 3;

    // low 32 bits of 2*pi in Q0.32; the upper part is 6
    localparam logic [DATA_W-1:0] TWO_PI_LO = 32'd1216271633;

    localparam logic [DATA_W-1:0] SPRING_RST  = 32'd655360;
    localparam logic [DATA_W-1:0] DAMPING_RST = 32'd163840;
    localparam logic [DATA_W-1:0] INV_MASS_RST = 32'd655360;
    localparam logic [DATA_W-1:0] TICK_RST    = 32'd655;
    localparam logic [LIM_W-1:0]  ACCEL_RST   = 31'd2621440;
    localparam logic [LIM_W-1:0]  RATE_RST    = 31'd786432;
    localparam logic [LIM_W-1:0]  SPEED_RST   = 31'd786432;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPRING   = 3'd0,
        CFG_DAMPING  = 3'd1,
        CFG_INV_MASS = 3'd2,
        CFG_TICK     = 3'd3,
        CFG_ACCEL    = 3'd4,
        CFG_RATE     = 3'd5,
        CFG_SPEED    = 3'd6
    } cfg_index_t;

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_RAD_LO = 15'b000000000000010,
        S_RAD_W  = 15'b000000000000100,
        S_RAD_HI = 15'b000000000001000,
        S_SPR    = 15'b000000000010000,
        S_SPR_W  = 15'b000000000100000,
        S_DMP    = 15'b000000001000000,
        S_FRC    = 15'b000000010000000,
        S_MAS    = 15'b000000100000000,
        S_MAS_W  = 15'b000001000000000,
        S_ACC    = 15'b000010000000000,
        S_TCK    = 15'b000100000000000,
        S_TCK_W  = 15'b001000000000000,
        S_RATE   = 15'b010000000000000,
        S_FIN    = 15'b100000000000000
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] a;
        logic        [DATA_W-1:0] b;
    } mul_req_t;

    function automatic logic signed [DATA_W-1:0] clamp_sym(
        input logic signed [WIDE_W-1:0] v,
        input logic        [LIM_W-1:0]  lim
    );
        logic signed [WIDE_W-1:0] lim_s;
        logic signed [DATA_W-1:0] r;
        lim_s = $signed({{(WIDE_W-LIM_W){1'b0}}, lim});
        if (v > lim_s) begin
            r = lim_s[DATA_W-1:0];
        end else if (v < -lim_s) begin
            r = DATA_W'(-lim_s);
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        logic signed [DATA_W-1:0] r;
        hi = $signed({{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
        lo = $signed({{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});
        if (v > hi) begin
            r = hi[DATA_W-1:0];
        end else if (v < lo) begin
            r = lo[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/sic_mul_unit.sv =====
// Shared signed-by-unsigned 32x32 multiplier, two register stages.
// Depends on sic_pkg (mul_req_t, widths).
`default_nettype none

module sic_mul_unit (
    input  wire logic                              clk,
    input  wire sic_pkg::mul_req_t                 req,
    output logic signed [sic_pkg::WIDE_W-1:0]      res
);
    import sic_pkg::*;

    logic [DATA_W-1:0]        mag;
    logic [2*DATA_W-1:0]      prod_reg;
    logic                     neg_reg;
    logic signed [WIDE_W-1:0] prod_ext;
    logic signed [WIDE_W-1:0] res_reg;

    assign mag      = req.a[DATA_W-1] ? DATA_W'(~req.a + 1'b1) : req.a;
    assign prod_ext = $signed({{(WIDE_W-2*DATA_W){1'b0}}, prod_reg});
    assign res      = res_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= {{DATA_W{1'b0}}, mag} * {{DATA_W{1'b0}}, req.b};
        neg_reg  <= req.a[DATA_W-1];
        res_reg  <= neg_reg ? -prod_ext : prod_ext;
    end

endmodule

`default_nettype wire

// ===== src/steer_impedance_controller_core.sv =====
// Top level of the per-wheel steering impedance controller.
// Depends on sic_pkg, sic_mul_unit and steer_impedance_controller_core_macros.svh.
`default_nettype none
`include "steer_impedance_controller_core_macros.svh"

// One item is one control tick of one wheel. For a regular tick a small sequencer runs the
// angle-to-radian scaling, spring, damping, reciprocal mass and integration products one
// after another through a single shared, registered 32x32 multiplier, then loads the result
// register and returns to idle; a new tick is not taken until the last one is through.
// Stop items and items for a wheel beyond NUM_WHEELS go from idle straight to the finishing
// state and load the result register from there. A new item is taken once the sequencer is
// back in idle, even while the last result still waits in the output register; a finished
// item that finds that register still full holds the sequencer until the waiting result is
// taken. Configuration writes are taken every cycle and belong in gaps with no item in
// flight.
module steer_impedance_controller_core #(
    parameter int NUM_WHEELS = 4,
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,

    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [sic_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [sic_pkg::DATA_W-1:0]             cfg_data,

    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic                                   stop,
    input  wire logic [sic_pkg::WHEEL_W-1:0]            wheel,
    input  wire logic [ANGLE_BITS-1:0]                  measured_angle,
    input  wire logic [ANGLE_BITS-1:0]                  target_angle,
    input  wire logic signed [sic_pkg::DATA_W-1:0]      drive_target,

    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [sic_pkg::DATA_W-1:0]           steer_velocity_cmd,
    output logic signed [sic_pkg::DATA_W-1:0]           drive_velocity_cmd,
    output logic [ANGLE_BITS-1:0]                       steer_angle_cmd,
    output logic [sic_pkg::WHEEL_W-1:0]                 out_wheel
);
    import sic_pkg::*;

    localparam int WIDX_W    = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
    localparam int RAD_SHIFT = DATA_W + ANGLE_BITS - FRAC_BITS;

    // configuration
    logic [DATA_W-1:0] spring_reg, damping_reg, inv_mass_reg, tick_reg;
    logic [LIM_W-1:0]  accel_lim_reg, rate_lim_reg, speed_lim_reg;

    // sequencer and per-wheel state
    state_t                   state_reg, state_next;
    logic signed [DATA_W-1:0] steer_rate_reg [NUM_WHEELS];
    logic [ANGLE_BITS-1:0]    held_angle_reg [NUM_WHEELS];
    logic                     out_valid_reg;

    // datapath
    logic signed [DATA_W-1:0] opa_reg, opa_next;
    logic signed [DATA_W-1:0] rate_reg;
    logic signed [DATA_W-1:0] nr_reg;
    logic signed [WIDE_W-1:0] force_reg;
    logic [WIDX_W-1:0]        widx_reg;
    logic [WHEEL_W-1:0]       wheel_reg;
    logic                     bypass_reg;
    logic signed [DATA_W-1:0] drive_res_reg;
    logic [ANGLE_BITS-1:0]    angle_res_reg;

    logic signed [DATA_W-1:0] steer_out_reg;
    logic signed [DATA_W-1:0] drive_out_reg;
    logic [ANGLE_BITS-1:0]    angle_out_reg;
    logic [WHEEL_W-1:0]       wheel_out_reg;

    mul_req_t                 mreq;
    logic signed [WIDE_W-1:0] mul_res;
    logic signed [WIDE_W-1:0] mul_shift;
    logic signed [WIDE_W-1:0] err_ext;
    logic signed [WIDE_W-1:0] rad_sum;
    logic signed [WIDE_W-1:0] rad_val;
    logic signed [DATA_W-1:0] nr_val;
    logic [ANGLE_BITS-1:0]    ang_diff;
    logic [WIDX_W-1:0]        widx;
    logic                     wheel_ok;
    logic                     accept;
    logic                     fin_load;
    logic                     rate_nz;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign fin_load  = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign wheel_ok  = (32'(wheel) < NUM_WHEELS);
    assign widx      = WIDX_W'(wheel);
    assign ang_diff  = target_angle - measured_angle;

    assign mul_shift = mul_res >>> FRAC_BITS;
    assign err_ext   = WIDE_W'(opa_reg);
    // 2*pi upper part: 6 = 4 + 2
    assign rad_sum   = mul_res + (err_ext <<< (DATA_W + 2)) + (err_ext <<< (DATA_W + 1));
    assign rad_val   = rad_sum >>> RAD_SHIFT;
    assign nr_val    = clamp_sym(WIDE_W'(rate_reg) + mul_shift, rate_lim_reg);

    always_comb
    begin
        rate_nz = 1'b0;
        for (int i = 0; i < NUM_WHEELS; i++) begin
            rate_nz = rate_nz | (steer_rate_reg[i] != '0);
        end
    end

    always_comb
    begin
        mreq.a = opa_reg;
        mreq.b = '0;
        case (state_reg)
            S_RAD_LO: mreq.b = TWO_PI_LO;
            S_SPR:    mreq.b = spring_reg;
            S_SPR_W:
            begin
                mreq.a = rate_reg;
                mreq.b = damping_reg;
            end
            S_MAS:    mreq.b = inv_mass_reg;
            S_TCK:    mreq.b = tick_reg;
            default:  mreq.b = '0;
        endcase
    end

    sic_mul_unit u_mul (
        .clk (clk),
        .req (mreq),
        .res (mul_res)
    );

    always_comb
    begin
        state_next = state_reg;
        opa_next   = opa_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    opa_next   = DATA_W'($signed(ang_diff));
                    state_next = (!stop && wheel_ok) ? S_RAD_LO : S_FIN;
                end
            end
            S_RAD_LO: state_next = S_RAD_W;
            S_RAD_W:  state_next = S_RAD_HI;
            S_RAD_HI:
            begin
                opa_next   = rad_val[DATA_W-1:0];
                state_next = S_SPR;
            end
            S_SPR:    state_next = S_SPR_W;
            S_SPR_W:  state_next = S_DMP;
            S_DMP:    state_next = S_FRC;
            S_FRC:
            begin
                opa_next   = sat32(force_reg - mul_shift);
                state_next = S_MAS;
            end
            S_MAS:    state_next = S_MAS_W;
            S_MAS_W:  state_next = S_ACC;
            S_ACC:
            begin
                opa_next   = clamp_sym(mul_shift, accel_lim_reg);
                state_next = S_TCK;
            end
            S_TCK:    state_next = S_TCK_W;
            S_TCK_W:  state_next = S_RATE;
            S_RATE:   state_next = S_FIN;
            S_FIN:
            begin
                if (fin_load) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            spring_reg    <= SPRING_RST;
            damping_reg   <= DAMPING_RST;
            inv_mass_reg  <= INV_MASS_RST;
            tick_reg      <= TICK_RST;
            accel_lim_reg <= ACCEL_RST;
            rate_lim_reg  <= RATE_RST;
            speed_lim_reg <= SPEED_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SPRING:   spring_reg    <= cfg_data;
                CFG_DAMPING:  damping_reg   <= cfg_data;
                CFG_INV_MASS: inv_mass_reg  <= cfg_data;
                CFG_TICK:     tick_reg      <= cfg_data;
                CFG_ACCEL:    accel_lim_reg <= cfg_data[LIM_W-1:0];
                CFG_RATE:     rate_lim_reg  <= cfg_data[LIM_W-1:0];
                CFG_SPEED:    speed_lim_reg <= cfg_data[LIM_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_WHEELS; i++) begin
                steer_rate_reg[i] <= '0;
                held_angle_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (fin_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (accept && stop) begin
                for (int i = 0; i < NUM_WHEELS; i++) begin
                    steer_rate_reg[i] <= '0;
                end
            end else if (accept && wheel_ok) begin
                held_angle_reg[widx] <= target_angle;
            end
            if (state_reg == S_RATE) begin
                steer_rate_reg[widx_reg] <= nr_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg <= opa_next;
        if (accept) begin
            wheel_reg <= wheel;
            widx_reg  <= widx;
            rate_reg  <= wheel_ok ? steer_rate_reg[widx] : '0;
            if (stop) begin
                bypass_reg    <= 1'b1;
                drive_res_reg <= '0;
                angle_res_reg <= wheel_ok ? held_angle_reg[widx] : '0;
            end else if (wheel_ok) begin
                bypass_reg    <= 1'b0;
                drive_res_reg <= drive_target;
                angle_res_reg <= target_angle;
            end else begin
                bypass_reg    <= 1'b1;
                drive_res_reg <= '0;
                angle_res_reg <= '0;
            end
        end
        if (state_reg == S_DMP) begin
            force_reg <= mul_shift;
        end
        if (state_reg == S_RATE) begin
            nr_reg <= nr_val;
        end
        if (fin_load) begin
            steer_out_reg <= bypass_reg ? '0 : clamp_sym(WIDE_W'(nr_reg), speed_lim_reg);
            drive_out_reg <= drive_res_reg;
            angle_out_reg <= angle_res_reg;
            wheel_out_reg <= wheel_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign steer_velocity_cmd = steer_out_reg;
    assign drive_velocity_cmd = drive_out_reg;
    assign steer_angle_cmd    = angle_out_reg;
    assign out_wheel          = wheel_out_reg;

    `SIC_ASSERT_NEXT(a_stop_clears_rates, accept && stop, !rate_nz, "stop item left a stored rate")
    `SIC_ASSERT_NEXT(a_stop_to_fin, accept && stop, state_reg == S_FIN, "stop item not finished at once")
    `SIC_ASSERT_NEXT(a_accept_busy, accept, state_reg != S_IDLE, "sequencer idle after accept")
    `SIC_ASSERT_NEXT(a_fin_valid, fin_load, out_valid_reg, "finished item not presented")

endmodule

`default_nettype wire
